[rtl/rfs_pkg.sv]
// ----------------------------------------------------------------------------
// Register file with shadow set: shared definitions
// Register numbers, operation and view codes, and the item types.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int NUM_REGISTERS = 9;
  localparam int NUM_SHADOW    = 4;
  localparam int REG_IDX_W     = $clog2(NUM_REGISTERS);
  localparam int REG_CNT_W     = REG_IDX_W + 1;

  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  localparam logic [3:0] KIND_READ    = 4'd0;
  localparam logic [3:0] KIND_WRITE   = 4'd1;
  localparam logic [3:0] KIND_INC     = 4'd2;
  localparam logic [3:0] KIND_DEC     = 4'd3;
  localparam logic [3:0] KIND_EXX     = 4'd4;
  localparam logic [3:0] KIND_EXDEHL  = 4'd5;
  localparam logic [3:0] KIND_EXAF    = 4'd6;
  localparam logic [3:0] KIND_BITSET  = 4'd7;
  localparam logic [3:0] KIND_BITCLR  = 4'd8;
  localparam logic [3:0] KIND_BITTEST = 4'd9;

  localparam logic [1:0] VIEW_WORD = 2'd0;
  localparam logic [1:0] VIEW_HIGH = 2'd1;
  localparam logic [1:0] VIEW_LOW  = 2'd2;

  localparam int IDX_AF = 0;
  localparam int IDX_BC = 1;
  localparam int IDX_DE = 2;
  localparam int IDX_HL = 3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  reg_number;
    logic [1:0]  view;
    logic [15:0] write_value;
    logic [2:0]  bit_number;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        bad_register;
  } rsp_t;

endpackage

[rtl/rfs_req_if.sv]
// ----------------------------------------------------------------------------
// Register file request channel
// Valid/ready channel that carries one access or exchange item.
// ----------------------------------------------------------------------------
interface rfs_req_if;

  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  reg_number;
  logic [1:0]  view;
  logic [15:0] write_value;
  logic [2:0]  bit_number;

  modport source (
    output valid, kind, reg_number, view, write_value, bit_number,
    input  ready
  );

  modport sink (
    input  valid, kind, reg_number, view, write_value, bit_number,
    output ready
  );

endinterface

[rtl/rfs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Register file response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface rfs_rsp_if;

  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        bad_register;

  modport source (
    output valid, read_data, bad_register,
    input  ready
  );

  modport sink (
    input  valid, read_data, bad_register,
    output ready
  );

endinterface

[rtl/rfs_core.sv]
// ----------------------------------------------------------------------------
// Register file core
// Main and shadow register storage with the read-modify-write logic for one
// item; state is updated on the cycle that the item is executed.
// ----------------------------------------------------------------------------
module rfs_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          exec,
  input  rfs_pkg::req_t req,
  output rfs_pkg::rsp_t rsp
);

  logic [15:0] main_regs   [rfs_pkg::NUM_REGISTERS];
  logic [15:0] shadow_regs [rfs_pkg::NUM_SHADOW];

  logic [rfs_pkg::REG_IDX_W-1:0] idx;
  logic                          uses_reg;
  logic                          bad;
  logic [15:0]                   cur_word;
  logic [15:0]                   view_val;
  logic [7:0]                    view_byte;
  logic [7:0]                    bit_mask;
  logic [15:0]                   new_val;
  logic [15:0]                   wr_word;
  logic                          wr_en;

  assign idx       = req.reg_number[rfs_pkg::REG_IDX_W-1:0];
  assign uses_reg  = req.kind inside {[rfs_pkg::KIND_READ:rfs_pkg::KIND_DEC],
                                      [rfs_pkg::KIND_BITSET:rfs_pkg::KIND_BITTEST]};
  assign bad       = uses_reg &&
                     ({1'b0, req.reg_number} >= rfs_pkg::REG_CNT_W'(rfs_pkg::NUM_REGISTERS));
  assign cur_word  = main_regs[idx];
  assign view_byte = view_val[7:0];
  assign bit_mask  = 8'(1) << req.bit_number;

  always_comb begin
    case (req.view)
      rfs_pkg::VIEW_HIGH: view_val = {8'h00, cur_word[15:8]};
      rfs_pkg::VIEW_LOW:  view_val = cur_word & rfs_pkg::BYTE_MASK;
      default:            view_val = cur_word;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    new_val = req.write_value;
    case (req.kind)
      rfs_pkg::KIND_WRITE: begin
        wr_en = 1'b1;
      end
      rfs_pkg::KIND_INC: begin
        wr_en   = 1'b1;
        new_val = view_val + 16'd1;
      end
      rfs_pkg::KIND_DEC: begin
        wr_en   = 1'b1;
        new_val = view_val - 16'd1;
      end
      rfs_pkg::KIND_BITSET: begin
        wr_en   = 1'b1;
        new_val = {8'h00, view_byte | bit_mask};
      end
      rfs_pkg::KIND_BITCLR: begin
        wr_en   = 1'b1;
        new_val = {8'h00, view_byte & ~bit_mask};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (req.view)
      rfs_pkg::VIEW_HIGH: wr_word = {new_val[7:0], cur_word[7:0]};
      rfs_pkg::VIEW_LOW:  wr_word = {cur_word[15:8], new_val[7:0]};
      default:            wr_word = new_val;
    endcase
  end

  always_comb begin
    rsp.bad_register = bad;
    rsp.read_data    = '0;
    if (!bad) begin
      case (req.kind)
        rfs_pkg::KIND_READ:    rsp.read_data = view_val;
        rfs_pkg::KIND_BITTEST: rsp.read_data = {15'd0, view_byte[req.bit_number]};
        default:               rsp.read_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rfs_pkg::NUM_REGISTERS; i++) begin
        main_regs[i] <= '0;
      end
      for (int i = 0; i < rfs_pkg::NUM_SHADOW; i++) begin
        shadow_regs[i] <= '0;
      end
    end else if (exec && !bad) begin
      case (req.kind)
        rfs_pkg::KIND_EXX: begin
          main_regs[rfs_pkg::IDX_BC]   <= shadow_regs[rfs_pkg::IDX_BC];
          main_regs[rfs_pkg::IDX_DE]   <= shadow_regs[rfs_pkg::IDX_DE];
          main_regs[rfs_pkg::IDX_HL]   <= shadow_regs[rfs_pkg::IDX_HL];
          shadow_regs[rfs_pkg::IDX_BC] <= main_regs[rfs_pkg::IDX_BC];
          shadow_regs[rfs_pkg::IDX_DE] <= main_regs[rfs_pkg::IDX_DE];
          shadow_regs[rfs_pkg::IDX_HL] <= main_regs[rfs_pkg::IDX_HL];
        end
        rfs_pkg::KIND_EXDEHL: begin
          main_regs[rfs_pkg::IDX_DE] <= main_regs[rfs_pkg::IDX_HL];
          main_regs[rfs_pkg::IDX_HL] <= main_regs[rfs_pkg::IDX_DE];
        end
        rfs_pkg::KIND_EXAF: begin
          main_regs[rfs_pkg::IDX_AF]   <= shadow_regs[rfs_pkg::IDX_AF];
          shadow_regs[rfs_pkg::IDX_AF] <= main_regs[rfs_pkg::IDX_AF];
        end
        default: begin
          if (wr_en) begin
            main_regs[idx] <= wr_word;
          end
        end
      endcase
    end
  end

endmodule

[rtl/cpu_register_file_with_shadow_set_unit.sv]
// ----------------------------------------------------------------------------
// Register file with shadow set
// Top level: input register, execution core and result register.
// ----------------------------------------------------------------------------
// Each item is taken into an input register, executed against the register
// file once the output register is empty or its result is being taken, and
// its own result is held in the output register until it is taken. The block
// accepts one item per cycle while results are taken, and each result is
// registered after execution. A stalled result holds back the item behind
// it, and each item sees the state left by all earlier items.
module cpu_register_file_with_shadow_set_unit (
  input  logic       clk,
  input  logic       rst,
  rfs_req_if.sink    req,
  rfs_rsp_if.source  rsp
);

  rfs_pkg::req_t in_item;
  logic          in_valid;
  rfs_pkg::rsp_t exec_rsp;
  rfs_pkg::rsp_t out_item;
  logic          out_valid;
  logic          exec;

  assign exec      = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.kind        <= req.kind;
      in_item.reg_number  <= req.reg_number;
      in_item.view        <= req.view;
      in_item.write_value <= req.write_value;
      in_item.bit_number  <= req.bit_number;
    end
  end

  rfs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .exec (exec),
    .req  (in_item),
    .rsp  (exec_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_item <= exec_rsp;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_item.read_data;
  assign rsp.bad_register = out_item.bad_register;

endmodule

[test/rfs_access_checker.sv]
// ----------------------------------------------------------------------------
// Register file with shadow set: access checker
// Watches the request and result channels, keeps its own copy of the main and
// shadow registers, works out the result of every accepted item and compares
// each accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module rfs_access_checker (
  input  logic        clk,
  input  logic        rst,
  rfs_req_if          req,
  rfs_rsp_if          rsp,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned compared,
  output int unsigned flagged
);

  import rfs_pkg::*;

  logic [15:0] main_file [NUM_REGISTERS];
  logic [15:0] shadow_file [NUM_SHADOW];
  rsp_t        outstanding_results [$];

  function automatic logic [15:0] view_get(input logic [15:0] word, input logic [1:0] view);
    case (view)
      VIEW_HIGH: return {8'h00, word[15:8]};
      VIEW_LOW:  return {8'h00, word[7:0]};
      default:   return word;
    endcase
  endfunction

  function automatic logic [15:0] view_put(input logic [15:0] word, input logic [1:0] view,
                                           input logic [15:0] value);
    case (view)
      VIEW_HIGH: return {value[7:0], word[7:0]};
      VIEW_LOW:  return {word[15:8], value[7:0]};
      default:   return value;
    endcase
  endfunction

  task automatic swap_with_shadow(input int idx);
    logic [15:0] held;
    held             = main_file[idx];
    main_file[idx]   = shadow_file[idx];
    shadow_file[idx] = held;
  endtask

  task automatic execute_access(input req_t item, output rsp_t result);
    logic        uses_reg;
    logic [15:0] word;
    logic [15:0] cur;
    logic [15:0] held;
    result   = '0;
    uses_reg = (item.kind <= KIND_DEC) ||
               (item.kind >= KIND_BITSET && item.kind <= KIND_BITTEST);
    if (uses_reg && item.reg_number >= NUM_REGISTERS) begin
      result.bad_register = 1'b1;
    end else begin
      if (uses_reg) begin
        word = main_file[item.reg_number];
        cur  = view_get(word, item.view);
      end
      case (item.kind)
        KIND_READ: begin
          result.read_data = cur;
        end
        KIND_WRITE: begin
          main_file[item.reg_number] = view_put(word, item.view, item.write_value);
        end
        KIND_INC: begin
          main_file[item.reg_number] = view_put(word, item.view, cur + 16'h0001);
        end
        KIND_DEC: begin
          main_file[item.reg_number] = view_put(word, item.view, cur - 16'h0001);
        end
        KIND_EXX: begin
          swap_with_shadow(IDX_BC);
          swap_with_shadow(IDX_DE);
          swap_with_shadow(IDX_HL);
        end
        KIND_EXDEHL: begin
          held              = main_file[IDX_DE];
          main_file[IDX_DE] = main_file[IDX_HL];
          main_file[IDX_HL] = held;
        end
        KIND_EXAF: begin
          swap_with_shadow(IDX_AF);
        end
        KIND_BITSET: begin
          cur = cur & BYTE_MASK;
          main_file[item.reg_number] =
            view_put(word, item.view, cur | (16'h0001 << item.bit_number));
        end
        KIND_BITCLR: begin
          cur = cur & BYTE_MASK;
          main_file[item.reg_number] =
            view_put(word, item.view, cur & ~(16'h0001 << item.bit_number) & BYTE_MASK);
        end
        KIND_BITTEST: begin
          cur = cur & BYTE_MASK;
          result.read_data = {15'd0, cur[item.bit_number]};
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
    errors++;
    $display("checker: %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    req_t item;
    rsp_t predicted;
    rsp_t oldest;
    if (rst) begin
      foreach (main_file[i]) main_file[i] = '0;
      foreach (shadow_file[i]) shadow_file[i] = '0;
      outstanding_results.delete();
      errors   = 0;
      pending  = 0;
      compared = 0;
      flagged  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outstanding_results.size() == 0) begin
          report("result with no item outstanding", 16'h0000, rsp.read_data);
        end else begin
          oldest = outstanding_results.pop_front();
          compared++;
          if (rsp.read_data !== oldest.read_data) begin
            report("read_data", oldest.read_data, rsp.read_data);
          end
          if (rsp.bad_register !== oldest.bad_register) begin
            report("bad_register", {15'd0, oldest.bad_register}, {15'd0, rsp.bad_register});
          end
        end
      end
      if (req.valid && req.ready) begin
        item.kind        = req.kind;
        item.reg_number  = req.reg_number;
        item.view        = req.view;
        item.write_value = req.write_value;
        item.bit_number  = req.bit_number;
        execute_access(item, predicted);
        if (predicted.bad_register) begin
          flagged++;
        end
        outstanding_results.push_back(predicted);
      end
      pending = outstanding_results.size();
    end
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Register file with shadow set: testbench
// Drives a directed run through the edge cases and then random accesses and
// exchanges under three idling patterns, while the access checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb;

  import rfs_pkg::*;

  localparam logic [1:0]  VIEW_SPARE   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned send_idle_pct = 25;
  int unsigned recv_stall_pct = 56;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned compared_count;
  int unsigned flagged_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rfs_req_if req_ch ();
  rfs_rsp_if rsp_ch ();

  cpu_register_file_with_shadow_set_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rfs_access_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .errors   (fail_count),
    .pending  (pending_count),
    .compared (compared_count),
    .flagged  (flagged_count)
  );

  function automatic req_t make_item(input logic [3:0] kind, input logic [3:0] reg_number,
                                     input logic [1:0] view, input logic [15:0] value,
                                     input logic [2:0] bit_number);
    req_t item;
    item.kind        = kind;
    item.reg_number  = reg_number;
    item.view        = view;
    item.write_value = value;
    item.bit_number  = bit_number;
    return item;
  endfunction

  function automatic req_t random_item();
    req_t        item;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      item.kind = 4'($urandom_range(15, KIND_BITTEST + 1));
    end else if (pick < 35) begin
      item.kind = KIND_READ;
    end else begin
      item.kind = 4'($urandom_range(KIND_BITTEST, KIND_READ));
    end
    if ($urandom_range(9) == 0) begin
      item.reg_number = 4'($urandom_range(15, NUM_REGISTERS));
    end else begin
      item.reg_number = 4'($urandom_range(NUM_REGISTERS - 1, 0));
    end
    item.view = 2'($urandom_range(3, 0));
    case ($urandom_range(7))
      0:       item.write_value = 16'h0000;
      1:       item.write_value = 16'hFFFF;
      2:       item.write_value = 16'h00FF;
      3:       item.write_value = 16'hFF00;
      default: item.write_value = 16'($urandom);
    endcase
    item.bit_number = 3'($urandom_range(7, 0));
    return item;
  endfunction

  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.kind        = item.kind;
    req_ch.reg_number  = item.reg_number;
    req_ch.view        = item.view;
    req_ch.write_value = item.write_value;
    req_ch.bit_number  = item.bit_number;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_READ;
    req_ch.reg_number  = 4'd0;
    req_ch.view        = VIEW_WORD;
    req_ch.write_value = 16'h0000;
    req_ch.bit_number  = 3'd0;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: cycle limit reached with %0d results outstanding", pending_count);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int unsigned k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(make_item(KIND_WRITE, 4'(IDX_AF), VIEW_WORD, 16'hFFFF, 3'd0));
    send_item(make_item(KIND_INC, 4'(IDX_AF), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_DEC, 4'(IDX_AF), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_READ, 4'(IDX_AF), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_WRITE, 4'(NUM_REGISTERS - 1), VIEW_WORD, 16'h8001, 3'd0));
    send_item(make_item(KIND_READ, 4'(NUM_REGISTERS - 1), VIEW_HIGH, 16'h0000, 3'd0));
    send_item(make_item(KIND_WRITE, 4'(IDX_DE), VIEW_LOW, 16'hFFFF, 3'd0));
    send_item(make_item(KIND_INC, 4'(IDX_DE), VIEW_LOW, 16'h0000, 3'd0));
    send_item(make_item(KIND_DEC, 4'(IDX_DE), VIEW_HIGH, 16'h0000, 3'd0));
    send_item(make_item(KIND_READ, 4'(IDX_DE), VIEW_SPARE, 16'h0000, 3'd0));
    send_item(make_item(KIND_WRITE, 4'(IDX_HL), VIEW_WORD, 16'h1234, 3'd0));
    send_item(make_item(KIND_EXX, 4'hF, VIEW_SPARE, 16'hFFFF, 3'd7));
    send_item(make_item(KIND_READ, 4'(IDX_HL), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_EXAF, 4'hF, VIEW_SPARE, 16'hFFFF, 3'd7));
    send_item(make_item(KIND_READ, 4'(IDX_AF), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_EXX, 4'h0, VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_EXDEHL, 4'hF, VIEW_SPARE, 16'hFFFF, 3'd7));
    send_item(make_item(KIND_READ, 4'(IDX_DE), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_BITSET, 4'(IDX_DE), VIEW_WORD, 16'h0000, 3'd7));
    send_item(make_item(KIND_BITCLR, 4'(IDX_DE), VIEW_LOW, 16'h0000, 3'd2));
    send_item(make_item(KIND_BITTEST, 4'(IDX_DE), VIEW_LOW, 16'h0000, 3'd7));
    send_item(make_item(KIND_BITTEST, 4'(IDX_DE), VIEW_HIGH, 16'h0000, 3'd0));
    send_item(make_item(KIND_READ, 4'(NUM_REGISTERS), VIEW_WORD, 16'h0000, 3'd0));
    send_item(make_item(KIND_WRITE, 4'hF, VIEW_WORD, 16'hFFFF, 3'd0));
    send_item(make_item(4'hF, 4'hF, VIEW_SPARE, 16'hFFFF, 3'd7));

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 56;
        recv_stall_pct = 25;
      end
      if (k == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_item(random_item());
    end
    req_ch.valid = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d items sent under three idling patterns, %0d results compared",
             items_sent, compared_count);
    $display("tb: %0d results flagged a bad register number", flagged_count);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rfs_pkg.sv
rtl/rfs_req_if.sv
rtl/rfs_rsp_if.sv
rtl/rfs_core.sv
rtl/cpu_register_file_with_shadow_set_unit.sv
test/rfs_access_checker.sv
test/tb.sv
